// ===== rtl/assert_macros.svh =====
// assertion macros shared by the encoder rtl
// clocked on clk, disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle
`define B32_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the next cycle
`define B32_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/b32enc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32enc_pkg
// Types, constants and the symbol lookup of the base32 stream encoder.
// ----------------------------------------------------------------------------
package b32enc_pkg;

    localparam int BYTE_W  = 8;
    localparam int GROUP_W = 5;
    localparam int ACC_W   = 12;
    localparam int CNT_W   = 4;
    localparam int SYM_W   = 8;
    localparam int LETTERS = 26;

    localparam logic [GROUP_W-1:0] GROUP_MASK = 5'h1F;
    localparam logic [SYM_W-1:0]   CHAR_A     = 8'h61;
    localparam logic [SYM_W-1:0]   CHAR_2     = 8'h32;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_message;
    } in_beat_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last_symbol;
    } out_beat_t;

    typedef struct packed {
        logic               avail;
        logic               last;
        logic               frees;
        logic [GROUP_W-1:0] group;
    } acc_status_t;

    // a-z for 0..25, 2-7 for 26..31
    function automatic logic [SYM_W-1:0] b32_char(input logic [GROUP_W-1:0] grp);
        logic [GROUP_W-1:0] g;
        logic [SYM_W-1:0]   ch;
        g = grp & GROUP_MASK;
        if (g < GROUP_W'(LETTERS))
        begin
            ch = CHAR_A + SYM_W'(g);
        end
        else
        begin
            ch = CHAR_2 + SYM_W'(g - GROUP_W'(LETTERS));
        end
        return ch;
    endfunction

endpackage

// ===== rtl/b32enc_acc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32enc_acc
// Bit accumulator: left-aligned shift register that takes a byte behind the
// pending bits and shifts out one 5-bit group per emitted character.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b32enc_acc
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  b32enc_pkg::in_beat_t   data,
    input  logic                   emit,
    output b32enc_pkg::acc_status_t status
);

    logic [b32enc_pkg::ACC_W-1:0] acc_reg;
    logic [b32enc_pkg::ACC_W-1:0] acc_next;
    logic [b32enc_pkg::CNT_W-1:0] cnt_reg;
    logic [b32enc_pkg::CNT_W-1:0] cnt_next;
    logic                         last_reg;
    logic                         last_next;

    logic [b32enc_pkg::ACC_W-1:0] base_acc;
    logic [b32enc_pkg::CNT_W-1:0] base_cnt;
    logic                         base_last;
    logic [b32enc_pkg::ACC_W-1:0] byte_aligned;

    localparam logic [b32enc_pkg::CNT_W-1:0] GRP_CNT = b32enc_pkg::CNT_W'(b32enc_pkg::GROUP_W);
    localparam logic [b32enc_pkg::CNT_W-1:0] BYTE_CNT = b32enc_pkg::CNT_W'(b32enc_pkg::BYTE_W);
    localparam logic [b32enc_pkg::CNT_W-1:0] TWO_GRP =
        b32enc_pkg::CNT_W'(2 * b32enc_pkg::GROUP_W);
    localparam logic [b32enc_pkg::CNT_W-1:0] FULL_CNT = b32enc_pkg::CNT_W'(b32enc_pkg::ACC_W);

    always_comb
    begin
        status.group = acc_reg[b32enc_pkg::ACC_W-1 -: b32enc_pkg::GROUP_W];
        status.avail = (cnt_reg >= GRP_CNT) || (last_reg && (cnt_reg != '0));
        status.last  = last_reg && (cnt_reg <= GRP_CNT);
        status.frees = last_reg ? (cnt_reg <= GRP_CNT) : (cnt_reg < TWO_GRP);
    end

    assign byte_aligned = {data.data_byte, {(b32enc_pkg::ACC_W - b32enc_pkg::BYTE_W){1'b0}}};

    always_comb
    begin
        base_acc  = acc_reg;
        base_cnt  = cnt_reg;
        base_last = last_reg;
        if (emit)
        begin
            if (status.last)
            begin
                base_acc  = '0;
                base_cnt  = '0;
                base_last = 1'b0;
            end
            else
            begin
                base_acc = acc_reg << b32enc_pkg::GROUP_W;
                base_cnt = cnt_reg - GRP_CNT;
            end
        end
        acc_next  = base_acc;
        cnt_next  = base_cnt;
        last_next = base_last;
        if (load)
        begin
            acc_next  = base_acc | (byte_aligned >> base_cnt[2:0]);
            cnt_next  = base_cnt + BYTE_CNT;
            last_next = data.end_of_message;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            cnt_reg  <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
        end
    end

    `B32_ASSERT(a_cnt_range, cnt_reg <= FULL_CNT, "bit count out of range")
    `B32_ASSERT_NEXT(a_load_cnt, load, cnt_reg >= BYTE_CNT, "byte load left too few bits")
    `B32_ASSERT_NEXT(a_flush_clear, emit && status.last && !load,
        (cnt_reg == '0) && !last_reg, "accumulator not cleared after last symbol")
    `B32_ASSERT(a_last_pending, !(last_reg && (cnt_reg == '0)), "end mark with no bits left")

endmodule

// ===== rtl/b32enc_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32enc_out
// Output register: maps a group to its character and holds the beat until
// the receiver takes it.
// ----------------------------------------------------------------------------
module b32enc_out
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  b32enc_pkg::acc_status_t status,
    output logic                    emit,
    output logic                    sym_valid,
    input  logic                    sym_stall,
    output b32enc_pkg::out_beat_t   sym_beat
);

    logic                  valid_reg;
    logic                  valid_next;
    b32enc_pkg::out_beat_t beat_reg;
    b32enc_pkg::out_beat_t beat_next;
    logic                  take;

    assign take = !valid_reg || !sym_stall;
    assign emit = status.avail && take;

    always_comb
    begin
        valid_next = valid_reg && sym_stall;
        beat_next  = beat_reg;
        if (emit)
        begin
            valid_next            = 1'b1;
            beat_next.symbol      = b32enc_pkg::b32_char(status.group);
            beat_next.last_symbol = status.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign sym_valid = valid_reg;
    assign sym_beat  = beat_reg;

endmodule

// ===== rtl/base32_stream_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32_stream_encoder
// Lower-case unpadded base32 encoder, one byte in, one character out a beat.
//
// byte channel: byte_valid / byte_stall / byte_beat carry a data byte and an
//   end-of-message flag; a beat is taken when valid is high and stall low.
// sym channel: sym_valid / sym_stall / sym_beat carry one ascii character
//   and a mark on the final character of the message.
// Each byte gives one or two characters, three when the end flag flushes
//   leftover bits; one character leaves the accumulator per cycle while the
//   receiver does not stall, and a byte yields about 1.6 characters on average.
// A byte can be taken in the cycle its predecessor's last character is emitted.
// A byte's first character passes the accumulator, then the output register.
// Reset clears the accumulator, the end mark and the output valid.
// While the receiver stalls, the output register holds its beat and the
//   accumulator stops, which stalls the byte channel once a character is pending.
// ----------------------------------------------------------------------------
module base32_stream_encoder
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  b32enc_pkg::in_beat_t  byte_beat,
    output logic                  sym_valid,
    input  logic                  sym_stall,
    output b32enc_pkg::out_beat_t sym_beat
);

    b32enc_pkg::acc_status_t status;
    logic                    emit;
    logic                    load;

    assign byte_stall = status.avail && !(emit && status.frees);
    assign load       = byte_valid && !byte_stall;

    b32enc_acc u_acc
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .data   (byte_beat),
        .emit   (emit),
        .status (status)
    );

    b32enc_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .emit      (emit),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym_beat  (sym_beat)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the base32 stream encoder. A driver offers bytes
// from a queue and an encoder model predicts every character and its end
// mark. A monitor compares each symbol beat against the oldest prediction.
// Directed messages come first, then random messages of random length.
// Both sides insert random gaps. The receiver also holds off for a long
// stretch, and the sender twice waits for the encoder to drain completely.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          RANDOM_BYTES  = 140;
    localparam int          LONG_HOLD     = 60;
    localparam int          LONG_HOLD_AT  = 80;
    localparam int          IDLE_LIMIT    = 1000;
    localparam int          TAIL_CYCLES   = 10;
    localparam logic [7:0]  ASCII_LOWER_A = "a";
    localparam logic [7:0]  ASCII_DIGIT_2 = "2";
    localparam int          LETTER_COUNT  = 26;

    typedef struct packed {
        b32enc_pkg::in_beat_t beat;
        logic                 drain_first;
    } byte_job_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  byte_valid = 1'b0;
    logic                  byte_stall;
    b32enc_pkg::in_beat_t  byte_beat = '0;
    logic                  sym_valid;
    logic                  sym_stall = 1'b0;
    b32enc_pkg::out_beat_t sym_beat;

    byte_job_t             bytes_to_send[$];
    b32enc_pkg::out_beat_t symbols_due[$];

    logic [3:0] held_bits = '0;
    logic [2:0] held_count = '0;

    int bytes_sent = 0;
    int gap_left = 0;
    int hold_left = 0;
    int symbols_owed = 0;
    int symbols_seen = 0;
    int idle_cycles = 0;
    int errors = 0;

    base32_stream_encoder dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_beat  (byte_beat),
        .sym_valid  (sym_valid),
        .sym_stall  (sym_stall),
        .sym_beat   (sym_beat)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] group_char(input logic [4:0] grp);
        if (grp < LETTER_COUNT)
        begin
            return ASCII_LOWER_A + 8'(grp);
        end
        return ASCII_DIGIT_2 + 8'(grp - LETTER_COUNT);
    endfunction

    // shifts one byte into the model accumulator and queues its characters
    function automatic int encode_byte(input b32enc_pkg::in_beat_t b);
        logic [11:0]           acc;
        logic [3:0]            held;
        logic [4:0]            grp;
        b32enc_pkg::out_beat_t chars[3];
        int                    cnt;
        int                    made;
        cnt = held_count;
        held = held_bits & (4'hF >> (4 - cnt));
        acc = {held, b.data_byte};
        cnt = cnt + 8;
        made = 0;
        while (cnt >= 5 && made < 3)
        begin
            grp = 5'(acc >> (cnt - 5));
            chars[made] = '{symbol: group_char(grp), last_symbol: 1'b0};
            made++;
            cnt = cnt - 5;
        end
        if (b.end_of_message)
        begin
            if (cnt > 0 && made < 3)
            begin
                grp = 5'(acc << (5 - cnt));
                chars[made] = '{symbol: group_char(grp), last_symbol: 1'b1};
                made++;
            end
            else if (made > 0)
            begin
                chars[made-1].last_symbol = 1'b1;
            end
            held_bits = '0;
            held_count = '0;
        end
        else
        begin
            held_bits = 4'(acc & ((12'h1 << cnt) - 12'h1));
            held_count = 3'(cnt);
        end
        for (int i = 0; i < made; i++)
        begin
            symbols_due.push_back(chars[i]);
        end
        return made;
    endfunction

    function automatic void add_byte(input logic [7:0] d, input logic eom,
                                     input logic drain);
        byte_job_t job;
        job.beat.data_byte = d;
        job.beat.end_of_message = eom;
        job.drain_first = drain;
        bytes_to_send.push_back(job);
    endfunction

    function automatic int sender_gap();
        if (bytes_sent >= 35 && bytes_sent < 110)
        begin
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_beat <= '0;
            gap_left <= 0;
        end
        else
        begin : drive_bytes
            logic      taken;
            int        made;
            int        gap;
            byte_job_t job;
            taken = byte_valid && !byte_stall;
            made = 0;
            if (taken)
            begin
                made = encode_byte(byte_beat);
                bytes_sent++;
                symbols_owed <= symbols_owed + made;
            end
            if (!byte_valid || taken)
            begin
                gap = taken ? sender_gap() : gap_left;
                if (gap > 0)
                begin
                    byte_valid <= 1'b0;
                    gap_left <= gap - 1;
                end
                else if (bytes_to_send.size() > 0 &&
                         (!bytes_to_send[0].drain_first ||
                          (!taken && symbols_owed == symbols_seen)))
                begin
                    job = bytes_to_send.pop_front();
                    byte_beat <= job.beat;
                    byte_valid <= 1'b1;
                    gap_left <= 0;
                end
                else
                begin
                    byte_valid <= 1'b0;
                    gap_left <= 0;
                end
            end
        end
    end

    // symbol monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin : watch_symbols
            int                    nxt;
            b32enc_pkg::out_beat_t want;
            nxt = (hold_left > 0) ? hold_left - 1 : 0;
            if (sym_valid && !sym_stall)
            begin
                if (symbols_due.size() == 0)
                begin
                    $error("unexpected beat: symbol %h last_symbol %b",
                           sym_beat.symbol, sym_beat.last_symbol);
                    errors++;
                end
                else
                begin
                    want = symbols_due.pop_front();
                    if (sym_beat.symbol !== want.symbol)
                    begin
                        $error("symbol expected %h actual %h",
                               want.symbol, sym_beat.symbol);
                        errors++;
                    end
                    if (sym_beat.last_symbol !== want.last_symbol)
                    begin
                        $error("last_symbol expected %b actual %b",
                               want.last_symbol, sym_beat.last_symbol);
                        errors++;
                    end
                    symbols_seen <= symbols_seen + 1;
                end
                if (symbols_seen + 1 == LONG_HOLD_AT)
                begin
                    nxt = LONG_HOLD;
                end
                else if (symbols_seen >= 150 && symbols_seen < 210)
                begin
                    nxt = 0;
                end
                else
                begin
                    nxt = $urandom_range(0, 3);
                end
            end
            hold_left <= nxt;
            sym_stall <= (nxt != 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (sym_valid && !sym_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL base32_stream_encoder");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        int            msg_len;
        int            pick;
        int            total;
        logic [7:0]    d;
        logic [7:0]    foobar[6];
        foobar = '{8'h66, 8'h6F, 8'h6F, 8'h62, 8'h61, 8'h72};

        // single byte messages, low and high extremes
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        // forty bits, ends with nothing left over
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hAA, 1'b0, 1'b0);
        add_byte(8'h55, 1'b0, 1'b0);
        add_byte(8'hF0, 1'b1, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(8'h01, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        add_byte(8'h55, 1'b0, 1'b0);
        add_byte(8'hAA, 1'b0, 1'b0);
        add_byte(8'h0F, 1'b0, 1'b0);
        add_byte(8'hF0, 1'b1, 1'b0);
        for (int i = 0; i < 6; i++)
        begin
            add_byte(foobar[i], (i == 5), 1'b0);
        end

        // random messages
        total = 0;
        while (total < RANDOM_BYTES)
        begin
            msg_len = $urandom_range(1, 8);
            for (int i = 0; i < msg_len; i++)
            begin
                pick = $urandom_range(0, 9);
                d = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
                add_byte(d, (i == msg_len - 1), (total == 0 || total == 120));
                total++;
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_to_send.size() != 0 || byte_valid || symbols_owed != symbols_seen)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (symbols_due.size() != 0)
        begin
            $error("symbols never emitted: %0d", symbols_due.size());
        end
        if (errors == 0 && symbols_due.size() == 0)
        begin
            $display("PASS base32_stream_encoder");
        end
        else
        begin
            $display("FAIL base32_stream_encoder");
        end
        $finish;
    end

endmodule
